// ----- rtl/core/gaps_pkg.sv -----
// Package for the grid path search: types, step costs, move tables and
// the integer square-root function used by the distance estimate. No dependencies.
`default_nettype none
package gaps_pkg;
  localparam int GridSideDef = 8;
  localparam int Cells = 64;
  localparam logic [9:0] StepStraight = 10'd10;
  localparam logic [9:0] StepDiag = 10'd14;

  typedef enum logic [1:0] {
    ST_STEP = 2'd0,
    ST_SAME = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_NO_ROUTE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_STAIL, S_PICK, S_NBR, S_UPD, S_TRACE, S_TSTEP,
    S_EPRE, S_EMIT, S_STAT
  } state_t;

  function automatic logic signed [1:0] move_dx(input logic [2:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: move_dx = 2'sd1;
      3'd3, 3'd4, 3'd5: move_dx = -2'sd1;
      default: move_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] move_dy(input logic [2:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: move_dy = 2'sd1;
      3'd5, 3'd6, 3'd7: move_dy = -2'sd1;
      default: move_dy = 2'sd0;
    endcase
  endfunction

  // 10 * floor(sqrt(dx^2+dy^2)) for |dx|,|dy| < 8
  function automatic logic [9:0] guess(input logic [2:0] ax, input logic [2:0] ay);
    logic [6:0] s;
    logic [3:0] r;
    s = 7'({4'd0, ax} * {4'd0, ax}) + 7'({4'd0, ay} * {4'd0, ay});
    r = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (7'(i * i) <= s) r = 4'(i);
    end
    guess = 10'(r) * 10'd10;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/grid_astar_path_search.sv -----
// Grid path search top level: A* over an 8-connected tile grid.
// Depends on gaps_pkg.
//
// Usage: load tile_map through cfg_we/cfg_data while busy is low. Raise start
// with the four coordinates; the beat is taken at an edge with busy low.
// A blocked endpoint or start equal to goal gives one status beat in the
// next cycle. Otherwise the tables are cleared, then each expansion scans
// all tiles for the open tile of lowest priority (ties to lowest index),
// closes the winner in S_STAIL and S_PICK, then takes each neighbour in turn
// through the shared add/compare unit in S_NBR and S_UPD.
// The route is traced back into a stack (S_TRACE, S_TSTEP) and emitted
// start first, one beat a cycle on result_valid, last on the final beat.
// A search with no route ends after a final scan that finds no open tile.
// Reset clears control state and tile_map; tables are swept at each start that passes the endpoint checks.
// The receiver cannot stall: each result is present for one cycle only.
`default_nettype none
module grid_astar_path_search #(
  parameter int GRID_SIDE = gaps_pkg::GridSideDef
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [63:0] cfg_data,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] start_x,
  input  wire logic [2:0] start_y,
  input  wire logic [2:0] goal_x,
  input  wire logic [2:0] goal_y,
  output logic            result_valid,
  output logic [2:0]      step_dir,
  output logic [1:0]      status,
  output logic            last
);
  import gaps_pkg::*;

  logic [63:0] tile_map;
  state_t state, state_next;
  logic [2:0] sx, sy, gx, gy;
  logic [1:0] stat_code;
  logic [5:0] idx;
  logic [5:0] best;
  logic       found;
  logic [9:0] best_p, best_g;
  logic [5:0] cur;
  logic [2:0] nd;
  logic [5:0] depth;
  logic [63:0] opn, cls;
  logic [9:0] cost_mem [Cells];
  logic [9:0] prio_mem [Cells];
  logic [2:0] came_mem [Cells];
  logic [2:0] stack [Cells];
  logic [9:0] prio_rd, cost_rd;
  logic [2:0] came_rd, stack_rd;
  logic [5:0] rd_addr, stk_addr;
  logic [9:0] start_p;

  function automatic logic pass(input logic [63:0] m, input logic [3:0] x,
                                input logic [3:0] y);
    pass = (x < 4'(GRID_SIDE)) && (y < 4'(GRID_SIDE)) && m[{y[2:0], x[2:0]}];
  endfunction

  // neighbour candidate
  logic [3:0] nx, ny;
  logic [5:0] ni;
  logic       nok;
  logic [9:0] ng, np, ax_g;
  logic [2:0] adx, ady;
  always_comb begin
    nx = 4'({1'b0, cur[2:0]} + 4'(signed'(move_dx(nd))));
    ny = 4'({1'b0, cur[5:3]} + 4'(signed'(move_dy(nd))));
    ni = {ny[2:0], nx[2:0]};
    adx = (nx[2:0] > gx) ? nx[2:0] - gx : gx - nx[2:0];
    ady = (ny[2:0] > gy) ? ny[2:0] - gy : gy - ny[2:0];
    ax_g = guess(adx, ady);
    ng = best_g + (nd[0] ? StepDiag : StepStraight);
    np = ng + ax_g;
    nok = !nx[3] && !ny[3] && pass(tile_map, nx, ny) && !cls[ni] &&
          (!opn[ni] || prio_rd > np);
  end

  // scan data arrives in the cycle after its address
  logic [5:0] scan_idx;
  logic       scan_hit;
  assign scan_idx = idx - 6'd1;
  assign scan_hit = (state == S_STAIL || idx != 6'd0) && opn[scan_idx] &&
                    (!found || prio_rd < best_p);

  assign start_p = guess((sx > gx) ? sx - gx : gx - sx,
                         (sy > gy) ? sy - gy : gy - sy);
  assign rd_addr = (state == S_SCAN) ? idx : ni;
  assign stk_addr = (state == S_EMIT) ? depth - 6'd2 : depth - 6'd1;

  logic [3:0] tx, ty;
  assign tx = 4'({1'b0, cur[2:0]} - 4'(signed'(move_dx(came_rd))));
  assign ty = 4'({1'b0, cur[5:3]} - 4'(signed'(move_dy(came_rd))));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (!pass(tile_map, {1'b0, start_x}, {1'b0, start_y}) ||
              !pass(tile_map, {1'b0, goal_x}, {1'b0, goal_y}) ||
              (start_x == goal_x && start_y == goal_y)) state_next = S_STAT;
          else state_next = S_CLEAR;
        end
      end
      S_CLEAR: if (idx == 6'd63) state_next = S_SCAN;
      S_SCAN: if (idx == 6'd63) state_next = S_STAIL;
      S_STAIL: state_next = S_PICK;
      S_PICK: begin
        if (!found) state_next = S_STAT;
        else if (best == {gy, gx}) state_next = S_TRACE;
        else state_next = S_NBR;
      end
      S_NBR: state_next = S_UPD;
      S_UPD: if (nd == 3'd7) state_next = S_SCAN; else state_next = S_NBR;
      S_TRACE: if (cur == {sy, sx} || depth == 6'd63) state_next = S_EPRE;
               else state_next = S_TSTEP;
      S_TSTEP: if (tx[3] || ty[3]) state_next = S_EPRE; else state_next = S_TRACE;
      S_EPRE: state_next = S_EMIT;
      S_EMIT: if (depth == 6'd1) state_next = S_IDLE;
      S_STAT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    result_valid = 1'b0;
    step_dir = 3'd0;
    status = ST_STEP;
    last = 1'b0;
    case (state)
      S_EMIT: begin
        result_valid = 1'b1;
        step_dir = stack_rd;
        last = (depth == 6'd1);
      end
      S_STAT: begin
        result_valid = 1'b1;
        status = stat_code;
        last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      cost_mem[idx] <= 10'd0;
      prio_mem[idx] <= (idx == {sy, sx}) ? start_p : 10'd0;
      came_mem[idx] <= 3'd0;
    end else if (state == S_UPD && nok) begin
      cost_mem[ni] <= ng;
      prio_mem[ni] <= np;
      came_mem[ni] <= nd;
    end
    if (state == S_TSTEP) stack[depth] <= came_rd;
    prio_rd <= prio_mem[rd_addr];
    cost_rd <= cost_mem[rd_addr];
    came_rd <= came_mem[cur];
    stack_rd <= stack[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tile_map <= 64'd0;
      opn <= 64'd0;
      cls <= 64'd0;
    end else begin
      state <= state_next;
      if (cfg_we) tile_map <= cfg_data;
      case (state)
        S_IDLE: begin
          sx <= start_x; sy <= start_y; gx <= goal_x; gy <= goal_y;
          idx <= 6'd0;
          opn <= 64'd0;
          cls <= 64'd0;
          if (!pass(tile_map, {1'b0, start_x}, {1'b0, start_y}) ||
              !pass(tile_map, {1'b0, goal_x}, {1'b0, goal_y})) stat_code <= ST_BLOCKED;
          else stat_code <= ST_SAME;
        end
        S_CLEAR: begin
          idx <= idx + 6'd1;
          found <= 1'b0;
          if (idx == 6'd63) opn[{sy, sx}] <= 1'b1;
        end
        S_SCAN, S_STAIL: begin
          if (scan_hit) begin
            found <= 1'b1;
            best <= scan_idx;
            best_p <= prio_rd;
            best_g <= cost_rd;
          end
          if (state == S_SCAN) idx <= idx + 6'd1;
        end
        S_PICK: begin
          nd <= 3'd0;
          cur <= best;
          depth <= 6'd0;
          found <= 1'b0;
          if (found) begin
            opn[best] <= 1'b0;
            cls[best] <= 1'b1;
          end else stat_code <= ST_NO_ROUTE;
        end
        S_UPD: begin
          if (nok) opn[ni] <= 1'b1;
          nd <= nd + 3'd1;
        end
        S_TSTEP: begin
          depth <= depth + 6'd1;
          cur <= {ty[2:0], tx[2:0]};
        end
        S_EMIT: depth <= depth - 6'd1;
        default: ;
      endcase
    end
  end

  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid) else $error("beat after last");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result while idle");
  a_stat_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_STEP |-> last && step_dir == 3'd0)
    else $error("status beat malformed");
  a_closed: assert property (@(posedge clk) disable iff (rst)
    state == S_NBR |-> (opn & cls) == 64'd0) else $error("tile open and closed");
endmodule
`default_nettype wire

// ----- tb/sv/grid_astar_path_search_tb.sv -----
// Testbench for grid_astar_path_search: drives start/goal pairs against a
// range of tile maps and checks every result beat against an in-bench A* search.
// Depends on gaps_pkg and the grid_astar_path_search RTL.
`timescale 1ns / 100ps
`default_nettype none
module grid_astar_path_search_tb;
  import gaps_pkg::*;

  typedef struct packed {
    logic [2:0] dir;
    status_t    stat;
    logic       fin;
  } route_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  start_x = '0, start_y = '0, goal_x = '0, goal_y = '0;
  logic        result_valid;
  logic [2:0]  step_dir;
  logic [1:0]  status;
  logic        last;

  logic [63:0] map_model = '0;
  route_beat_t route_q[$];
  int          fail_cnt = 0;

  always #5 clk = ~clk;

  grid_astar_path_search dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .start_x(start_x), .start_y(start_y), .goal_x(goal_x), .goal_y(goal_y),
    .result_valid(result_valid), .step_dir(step_dir), .status(status), .last(last)
  );

  function automatic int dxof(int d);
    case (d)
      0, 1, 7: return 1;
      3, 4, 5: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int dyof(int d);
    case (d)
      1, 2, 3: return 1;
      5, 6, 7: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic bit open_tile(int x, int y);
    if (x < 0 || y < 0 || x > 7 || y > 7) return 1'b0;
    return map_model[y * 8 + x];
  endfunction

  function automatic int est(int x, int y, int gx, int gy);
    int s, r;
    s = (gx - x) * (gx - x) + (gy - y) * (gy - y);
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return 10 * r;
  endfunction

  task automatic push_status(status_t st);
    route_beat_t b;
    b.dir = 3'd0;
    b.stat = st;
    b.fin = 1'b1;
    route_q.insert(route_q.size(), b);
  endtask

  // A* search; pushes expected beats
  task automatic plan_route(int sx, int sy, int gx, int gy);
    bit    opn[64], cls[64];
    int    g[64], f[64], par[64];
    int    rev[$];
    int    best, cx, cy, nx, ny, ni, ng, np, x, y, d;
    route_beat_t b;
    if (!open_tile(sx, sy) || !open_tile(gx, gy)) begin
      push_status(ST_BLOCKED);
      return;
    end
    if (sx == gx && sy == gy) begin
      push_status(ST_SAME);
      return;
    end
    for (int k = 0; k < 64; k++) begin
      opn[k] = 0; cls[k] = 0; g[k] = 0; f[k] = 0; par[k] = 0;
    end
    opn[sy * 8 + sx] = 1;
    f[sy * 8 + sx] = est(sx, sy, gx, gy);
    forever begin
      best = -1;
      for (int k = 0; k < 64; k++)
        if (opn[k] && (best < 0 || f[k] < f[best])) best = k;
      if (best < 0) begin
        push_status(ST_NO_ROUTE);
        return;
      end
      opn[best] = 0;
      cls[best] = 1;
      cx = best % 8;
      cy = best / 8;
      if (cx == gx && cy == gy) begin
        x = cx; y = cy;
        while (!(x == sx && y == sy) && rev.size() < 63) begin
          d = par[y * 8 + x];
          rev.push_front(d);
          x -= dxof(d);
          y -= dyof(d);
          if (x < 0 || x > 7 || y < 0 || y > 7) break;
        end
        foreach (rev[j]) begin
          b.dir = rev[j][2:0];
          b.stat = ST_STEP;
          b.fin = (j == rev.size() - 1);
          route_q.insert(route_q.size(), b);
        end
        return;
      end
      for (int i = 0; i < 8; i++) begin
        nx = cx + dxof(i);
        ny = cy + dyof(i);
        if (!open_tile(nx, ny)) continue;
        ni = ny * 8 + nx;
        if (cls[ni]) continue;
        ng = g[best] + ((i % 2) ? 14 : 10);
        np = ng + est(nx, ny, gx, gy);
        if (!opn[ni] || f[ni] > np) begin
          opn[ni] = 1; g[ni] = ng; f[ni] = np; par[ni] = i;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      route_beat_t e;
      if (route_q.size() == 0) begin
        $error("unexpected beat dir=%0d status=%0d last=%0d", step_dir, status, last);
        fail_cnt++;
      end else begin
        e = route_q.pop_front();
        if (step_dir !== e.dir) begin
          $error("step_dir exp %0d got %0d", e.dir, step_dir);
          fail_cnt++;
        end
        if (status !== e.stat) begin
          $error("status exp %0d got %0d", e.stat, status);
          fail_cnt++;
        end
        if (last !== e.fin) begin
          $error("last exp %0d got %0d", e.fin, last);
          fail_cnt++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_search(int sx, int sy, int gx, int gy);
    start <= 1'b1;
    start_x <= sx[2:0]; start_y <= sy[2:0]; goal_x <= gx[2:0]; goal_y <= gy[2:0];
    do @(posedge clk); while (busy);
    plan_route(sx, sy, gx, gy);
    start <= 1'b0;
    @(posedge clk);
    if ($urandom_range(0, 2) == 0) idle_gap();
  endtask

  task automatic drain();
    while (route_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_map(logic [63:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    map_model = m;
    @(posedge clk);
  endtask

  task automatic test_directed();
    load_map('0);
    send_search(0, 0, 7, 7);
    load_map('1);
    send_search(0, 0, 7, 7);
    send_search(7, 7, 0, 0);
    send_search(7, 0, 0, 7);
    send_search(0, 7, 7, 0);
    send_search(3, 3, 3, 3);
    send_search(0, 0, 7, 0);
    send_search(7, 3, 0, 3);
    send_search(2, 0, 2, 7);
    send_search(5, 7, 5, 0);
    for (int d = 0; d < 8; d++) send_search(3, 3, 3 + dxof(d), 3 + dyof(d));
    // wall across x=3, single gap at top
    load_map(64'hF7F7_F7F7_F7F7_F7FF);
    send_search(0, 4, 7, 4);
    send_search(3, 4, 7, 4);
    send_search(0, 4, 3, 4);
    // full wall, no route
    load_map(64'hF7F7_F7F7_F7F7_F7F7);
    send_search(0, 0, 7, 7);
    send_search(2, 2, 2, 2);
    load_map(64'h8000_0000_0000_0001);
    send_search(0, 0, 7, 7);
  endtask

  task automatic test_random_maps();
    logic [63:0] m;
    int dens, x, y;
    for (int p = 0; p < 10; p++) begin
      dens = $urandom_range(0, 3);
      m = {$urandom, $urandom};
      case (dens)
        0: m = m | {$urandom, $urandom};
        1: m = m | {$urandom, $urandom} | {$urandom, $urandom};
        2: m = m;
        default: m = '1;
      endcase
      load_map(m);
      for (int i = 0; i < 11; i++) begin
        // mostly passable endpoints, some arbitrary
        x = $urandom_range(0, 7); y = $urandom_range(0, 7);
        for (int t = 0; t < 8 && $urandom_range(0, 4) != 0 && !open_tile(x, y); t++) begin
          x = $urandom_range(0, 7); y = $urandom_range(0, 7);
        end
        begin
          int gx, gy;
          gx = $urandom_range(0, 7); gy = $urandom_range(0, 7);
          for (int t = 0; t < 8 && $urandom_range(0, 4) != 0 && !open_tile(gx, gy); t++)
          begin
            gx = $urandom_range(0, 7); gy = $urandom_range(0, 7);
          end
          send_search(x, y, gx, gy);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_maps();
    drain();
    if (fail_cnt == 0 && route_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
